[rtl/dsn_pkg.sv]
// shared types, constants, conversion and rounding helpers for the double square root pipeline
package dsn_pkg;

  localparam int MANT_W   = 53;              // significand with hidden one
  localparam int FRAC_W   = 52;              // stored fraction bits
  localparam int EXP_W    = 10;              // working exponent of internal values
  localparam int HEXP_W   = 12;              // unbiased exponent of the operand
  localparam int BIAS     = 1023;
  localparam int LZ_W     = 6;               // index of a bit in the fraction
  localparam int QUO_W    = MANT_W + 1;      // quotient bits incl. guard
  localparam int DIV_BPS  = 2;               // quotient bits per divider stage
  localparam int DIV_STAGES = QUO_W / DIV_BPS;
  localparam int ALN_W    = MANT_W + 3;      // significand plus guard, round, sticky

  // positive normal value: mant * 2^(expo - 52), mant in [2^52, 2^53)
  typedef struct packed {
    logic signed [EXP_W-1:0] expo;
    logic [MANT_W-1:0]       mant;
  } fp_t;

  // everything that rides along with one transaction
  typedef struct packed {
    logic                     special;
    logic [63:0]              sbits;
    logic                     err;
    logic                     odd;
    logic signed [HEXP_W-1:0] half_ex;
    fp_t                      m;
    fp_t                      e;
  } side_t;

  function automatic fp_t bits_to_fp(input logic [63:0] b);
    fp_t f;
    logic signed [11:0] t;
    t = signed'({1'b0, b[62:52]}) - 12'sd1023;
    f.expo = EXP_W'(t);
    f.mant = {1'b1, b[51:0]};
    return f;
  endfunction

  // round to nearest even, carry out of the significand bumps the exponent
  function automatic fp_t round_rne(input logic [MANT_W-1:0] mant, input logic g,
                                    input logic s, input logic signed [EXP_W-1:0] expo);
    fp_t f;
    logic [MANT_W:0] sum;
    sum = {1'b0, mant} + (MANT_W+1)'(g & (s | mant[0]));
    if (sum[MANT_W]) begin
      f.mant = sum[MANT_W:1];
      f.expo = expo + EXP_W'(1);
    end else begin
      f.mant = sum[MANT_W-1:0];
      f.expo = expo;
    end
    return f;
  endfunction

  // first guess coefficients
  localparam fp_t C_ODD_MUL  = bits_to_fp($realtobits(0.828427314758301));
  localparam fp_t C_ODD_ADD  = bits_to_fp($realtobits(0.297334909439087));
  localparam fp_t C_EVEN_MUL = bits_to_fp($realtobits(0.58578634262085));
  localparam fp_t C_EVEN_ADD = bits_to_fp($realtobits(0.42049503326416));

endpackage

[rtl/dsn_unpack.sv]
// operand classification, subnormal normalization and first-guess setup (two stages)
module dsn_unpack import dsn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [63:0] operand,
  output logic        out_valid,
  output fp_t         coef,
  output side_t       out_side
);

  logic              v1_r, v2_r;
  logic              special_r, err_r;
  logic [63:0]       sbits_r;
  logic [10:0]       ef_r;
  logic [FRAC_W-1:0] frac_r;
  logic [LZ_W-1:0]   p_r;
  fp_t               coef_r;
  side_t             side_r;

  logic              nan_c, zero_c, neg_c, inf_c;
  logic [LZ_W-1:0]   p_c;

  always_comb begin
    nan_c  = (operand[62:52] == 11'h7ff) && (operand[51:0] != '0);
    zero_c = (operand[62:0] == '0);
    inf_c  = (operand[62:52] == 11'h7ff);
    neg_c  = operand[63] && !nan_c && !zero_c;
    p_c    = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      if (operand[i]) p_c = LZ_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      special_r <= nan_c || zero_c || neg_c || inf_c;
      err_r     <= neg_c;
      sbits_r   <= neg_c ? 64'd0 : operand;
      ef_r      <= operand[62:52];
      frac_r    <= operand[51:0];
      p_r       <= p_c;
    end
  end

  // second stage: normalize, make the exponent even, pick coefficients
  logic signed [HEXP_W-1:0] ex_c, ex_adj_c;
  logic [MANT_W-1:0]        mant_c;
  logic                     odd_c;
  side_t                    side_c;

  always_comb begin
    if (ef_r != '0) begin
      mant_c = {1'b1, frac_r};
      ex_c   = HEXP_W'(ef_r) - HEXP_W'(BIAS - 1);
    end else begin
      mant_c = MANT_W'({1'b0, frac_r}) << (LZ_W'(FRAC_W) - p_r);
      ex_c   = HEXP_W'(p_r) - HEXP_W'(BIAS + FRAC_W - 2);
    end
    odd_c          = ex_c[0];
    ex_adj_c       = ex_c + HEXP_W'(odd_c);
    side_c.special = special_r;
    side_c.sbits   = sbits_r;
    side_c.err     = err_r;
    side_c.odd     = odd_c;
    side_c.half_ex = ex_adj_c >>> 1;
    side_c.m.mant  = mant_c;
    side_c.m.expo  = odd_c ? EXP_W'(-2) : EXP_W'(-1);
    side_c.e       = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_c;
      coef_r <= odd_c ? C_ODD_MUL : C_EVEN_MUL;
    end
  end

  assign out_valid = v2_r;
  assign coef      = coef_r;
  assign out_side  = side_r;

endmodule

[rtl/dsn_fmul.sv]
// positive double multiply, split partial products then sum then round (three stages)
module dsn_fmul import dsn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  fp_t   a,
  input  fp_t   b,
  input  side_t in_side,
  output logic  out_valid,
  output fp_t   prod,
  output side_t out_side
);

  localparam int LO_W = 27;
  localparam int HI_W = MANT_W - LO_W;
  localparam int P_W  = 2 * MANT_W;

  logic                    v1_r, v2_r, v3_r;
  logic [2*HI_W-1:0]       hh_r;
  logic [HI_W+LO_W-1:0]    hl_r, lh_r;
  logic [2*LO_W-1:0]       ll_r;
  logic signed [EXP_W-1:0] e1_r, e2_r;
  side_t                   s1_r, s2_r, s3_r;
  logic [P_W-1:0]          full_r;
  fp_t                     prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  logic [P_W-1:0] sum_c;
  fp_t            rnd_c;

  always_comb begin
    sum_c = (P_W'(hh_r) << (2 * LO_W))
          + ((P_W'(hl_r) + P_W'(lh_r)) << LO_W)
          + P_W'(ll_r);
    if (full_r[P_W-1]) begin
      rnd_c = round_rne(full_r[P_W-1 -: MANT_W], full_r[MANT_W-1],
                        |full_r[MANT_W-2:0], e2_r + EXP_W'(1));
    end else begin
      rnd_c = round_rne(full_r[P_W-2 -: MANT_W], full_r[MANT_W-2],
                        |full_r[MANT_W-3:0], e2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r   <= a.mant[MANT_W-1:LO_W] * b.mant[MANT_W-1:LO_W];
      hl_r   <= a.mant[MANT_W-1:LO_W] * b.mant[LO_W-1:0];
      lh_r   <= a.mant[LO_W-1:0] * b.mant[MANT_W-1:LO_W];
      ll_r   <= a.mant[LO_W-1:0] * b.mant[LO_W-1:0];
      e1_r   <= a.expo + b.expo;
      s1_r   <= in_side;
      full_r <= sum_c;
      e2_r   <= e1_r;
      s2_r   <= s1_r;
      prod_r <= rnd_c;
      s3_r   <= s2_r;
    end
  end

  assign out_valid = v3_r;
  assign prod      = prod_r;
  assign out_side  = s3_r;

endmodule

[rtl/dsn_fadd.sv]
// positive double add, align with sticky then add and round (two stages)
module dsn_fadd import dsn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  fp_t   a,
  input  fp_t   b,
  input  side_t in_side,
  output logic  out_valid,
  output fp_t   sum,
  output side_t out_side
);

  logic                    v1_r, v2_r;
  logic [ALN_W-1:0]        big_r, aln_r;
  logic signed [EXP_W-1:0] e1_r;
  side_t                   s1_r, s2_r;
  fp_t                     sum_r;

  fp_t              big_c, sml_c;
  logic [EXP_W-1:0] diff_c;
  logic [ALN_W-1:0] ext_c, aln_c;
  logic             stk_c;

  always_comb begin
    if (b.expo > a.expo) begin
      big_c = b;
      sml_c = a;
    end else begin
      big_c = a;
      sml_c = b;
    end
    diff_c = EXP_W'(big_c.expo - sml_c.expo);
    ext_c  = {sml_c.mant, 3'b000};
    if (diff_c >= EXP_W'(ALN_W)) begin
      aln_c = '0;
      stk_c = 1'b1;
    end else begin
      aln_c = ext_c >> diff_c;
      stk_c = (aln_c << diff_c) != ext_c;
    end
  end

  logic [ALN_W:0] add_c;
  fp_t            rnd_c;

  always_comb begin
    add_c = {1'b0, big_r} + {1'b0, aln_r};
    if (add_c[ALN_W]) begin
      rnd_c = round_rne(add_c[ALN_W -: MANT_W], add_c[3], |add_c[2:0], e1_r + EXP_W'(1));
    end else begin
      rnd_c = round_rne(add_c[ALN_W-1 -: MANT_W], add_c[2], |add_c[1:0], e1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      big_r <= {big_c.mant, 3'b000};
      aln_r <= aln_c | ALN_W'(stk_c);
      e1_r  <= big_c.expo;
      s1_r  <= in_side;
      sum_r <= rnd_c;
      s2_r  <= s1_r;
    end
  end

  assign out_valid = v2_r;
  assign sum       = sum_r;
  assign out_side  = s2_r;

endmodule

[rtl/dsn_fdiv.sv]
// positive double divide, restoring radix-2 array with DIV_BPS quotient bits per stage
module dsn_fdiv import dsn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  fp_t   a,
  input  fp_t   b,
  input  side_t in_side,
  output logic  out_valid,
  output fp_t   quo,
  output side_t out_side
);

  logic                    v_r   [0:DIV_STAGES];
  logic [QUO_W-1:0]        rem_r [0:DIV_STAGES];
  logic [QUO_W-1:0]        q_r   [0:DIV_STAGES];
  logic [MANT_W-1:0]       dvs_r [0:DIV_STAGES];
  logic signed [EXP_W-1:0] e_r   [0:DIV_STAGES];
  side_t                   s_r   [0:DIV_STAGES];
  logic                    vo_r;
  fp_t                     quo_r;
  side_t                   so_r;

  // pre-scale so the quotient lands in [1,2)
  logic lt_c;
  assign lt_c = a.mant < b.mant;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= lt_c ? {a.mant, 1'b0} : {1'b0, a.mant};
      q_r[0]   <= '0;
      dvs_r[0] <= b.mant;
      e_r[0]   <= a.expo - b.expo - EXP_W'(lt_c);
      s_r[0]   <= in_side;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_it
    logic [QUO_W-1:0] r_c, q_c;

    always_comb begin
      r_c = rem_r[k];
      q_c = q_r[k];
      for (int j = 0; j < DIV_BPS; j++) begin
        if (r_c >= {1'b0, dvs_r[k]}) begin
          r_c = r_c - {1'b0, dvs_r[k]};
          q_c = {q_c[QUO_W-2:0], 1'b1};
        end else begin
          q_c = {q_c[QUO_W-2:0], 1'b0};
        end
        r_c = {r_c[QUO_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k+1] <= 1'b0;
      else if (en) v_r[k+1] <= v_r[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= r_c;
        q_r[k+1]   <= q_c;
        dvs_r[k+1] <= dvs_r[k];
        e_r[k+1]   <= e_r[k];
        s_r[k+1]   <= s_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= v_r[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= round_rne(q_r[DIV_STAGES][QUO_W-1:1], q_r[DIV_STAGES][0],
                         rem_r[DIV_STAGES] != '0, e_r[DIV_STAGES]);
      so_r  <= s_r[DIV_STAGES];
    end
  end

  assign out_valid = vo_r;
  assign quo       = quo_r;
  assign out_side  = so_r;

endmodule

[rtl/dsn_newton.sv]
// one newton step e = (m / e + e) / 2 as divide then add then exact halving
module dsn_newton import dsn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  fp_t   e_in,
  input  side_t in_side,
  output logic  out_valid,
  output fp_t   e_out,
  output side_t out_side
);

  side_t side_c, side_q, side_s;
  logic  v_q, v_s;
  fp_t   q, s;

  always_comb begin
    side_c   = in_side;
    side_c.e = e_in;
  end

  dsn_fdiv u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .a(in_side.m), .b(e_in), .in_side(side_c),
    .out_valid(v_q), .quo(q), .out_side(side_q)
  );

  dsn_fadd u_add (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_q),
    .a(q), .b(side_q.e), .in_side(side_q),
    .out_valid(v_s), .sum(s), .out_side(side_s)
  );

  assign out_valid  = v_s;
  assign e_out.mant = s.mant;
  assign e_out.expo = s.expo - EXP_W'(1);
  assign out_side   = side_s;

endmodule

[rtl/double_sqrt_newton.sv]
// top level: pipelined double-precision square root by newton iteration
//
//  channel   ports                                   direction  width
//  input     in_valid / in_ready / in_operand_bits   in         64
//  result    out_valid / out_ready / out_root_bits,  out        64 + 1
//            out_domain_error
//
// one transaction enters per cycle while in_ready is high (no stall at the result side);
// the depth is set by the quotient array, two bits per stage
// the whole pipe advances together whenever the result register is empty or taken
// a stall at the result side freezes every stage, so nothing is lost or repeated
// rst_n clears the valid bits of all stages; data registers keep no reset
module double_sqrt_newton import dsn_pkg::*; #(
  parameter int NEWTON_STEPS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_root_bits,
  output logic        out_domain_error
);

  // global advance: result register free or being drained this cycle
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // front end: classify and normalize operand
  logic  v_unp;
  fp_t   coef;
  side_t side_unp;

  dsn_unpack u_unpack (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .operand(in_operand_bits),
    .out_valid(v_unp), .coef(coef), .out_side(side_unp)
  );

  // linear first guess: m * c1 + c0
  logic  v_mul, v_g;
  fp_t   prod, guess;
  side_t side_mul, side_g;

  dsn_fmul u_mul (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_unp),
    .a(side_unp.m), .b(coef), .in_side(side_unp),
    .out_valid(v_mul), .prod(prod), .out_side(side_mul)
  );

  dsn_fadd u_add (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_mul),
    .a(prod), .b(side_mul.odd ? C_ODD_ADD : C_EVEN_ADD), .in_side(side_mul),
    .out_valid(v_g), .sum(guess), .out_side(side_g)
  );

  // chain of newton steps
  logic  v_ch    [0:NEWTON_STEPS];
  fp_t   e_ch    [0:NEWTON_STEPS];
  side_t side_ch [0:NEWTON_STEPS];

  assign v_ch[0]    = v_g;
  assign e_ch[0]    = guess;
  assign side_ch[0] = side_g;

  for (genvar n = 0; n < NEWTON_STEPS; n++) begin : g_step
    dsn_newton u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .in_valid(v_ch[n]),
      .e_in(e_ch[n]), .in_side(side_ch[n]),
      .out_valid(v_ch[n+1]), .e_out(e_ch[n+1]), .out_side(side_ch[n+1])
    );
  end

  // scale by 2^(ex/2) and merge the special cases
  side_t              side_f;
  fp_t                e_f;
  logic [HEXP_W-1:0]  bexp_c;
  logic [63:0]        root_c;
  logic [63:0]        root_r;
  logic               err_r;

  assign side_f = side_ch[NEWTON_STEPS];
  assign e_f    = e_ch[NEWTON_STEPS];

  always_comb begin
    bexp_c = HEXP_W'(side_f.half_ex) + HEXP_W'(e_f.expo) + HEXP_W'(BIAS);
    if (side_f.special) root_c = side_f.sbits;
    else root_c = {1'b0, bexp_c[10:0], e_f.mant[FRAC_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v_ch[NEWTON_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= root_c;
      err_r  <= side_f.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_root_bits    = root_r;
  assign out_domain_error = err_r;

  // a domain error always comes with a plus zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && err_r |-> root_r == 64'd0)
    else $error("domain error with nonzero root");

  // a stall freezes the front of the pipe
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_unp) && $stable(v_g))
    else $error("pipeline moved during stall");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
